// ===== sv/pcdq_pkg.sv =====
// Shared constants and types of the per-channel dequantizer.
package pcdq_pkg;

  localparam int MAX_CHANNELS = 1024;
  localparam int CH_W         = 10;
  localparam int COUNT_W      = 11;
  localparam int ETYPE_W      = 3;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 11;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_WEIGHT  = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  localparam logic [ETYPE_W-1:0] ET_INT8  = 3'd0;
  localparam logic [ETYPE_W-1:0] ET_INT4  = 3'd1;
  localparam logic [ETYPE_W-1:0] ET_INT2  = 3'd2;
  localparam logic [ETYPE_W-1:0] ET_UINT8 = 3'd3;
  localparam logic [ETYPE_W-1:0] ET_UINT4 = 3'd4;
  localparam logic [ETYPE_W-1:0] ET_UINT2 = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_TYPE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'b1;

  localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

  typedef struct packed {
    logic [31:0]        scale;
    logic signed [8:0]  zp;
    logic signed [9:0]  w;
    logic [CH_W-1:0]    ch;
    logic               last;
  } op_t;

endpackage

// ===== sv/pcdq_in_if.sv =====
// Input channel of the per-channel dequantizer.
interface pcdq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [9:0]  load_channel;
  logic [31:0] scale_bits;
  logic signed [8:0] zero_point;
  logic [7:0]  weight_byte;

  modport source (output valid, command, load_channel, scale_bits, zero_point, weight_byte,
                  input ready);
  modport sink (input valid, command, load_channel, scale_bits, zero_point, weight_byte,
                output ready);
endinterface

// ===== sv/pcdq_out_if.sv =====
// Result channel of the per-channel dequantizer.
interface pcdq_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_bits;
  logic [9:0]  channel_index;
  logic        row_end;

  modport source (output valid, value_bits, channel_index, row_end, input ready);
  modport sink (input valid, value_bits, channel_index, row_end, output ready);
endinterface

// ===== sv/pcdq_fmul.sv =====
// Pipelined fp32 scale times integer difference with round-to-nearest-even.
module pcdq_fmul (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          op_valid,
  output logic          op_ready,
  input  pcdq_pkg::op_t op,
  pcdq_out_if.source    out_ch
);

  // Multiply stage.
  logic signed [10:0] diff;
  logic               dneg;
  logic [9:0]         mag;
  logic [7:0]         e_raw;
  logic [23:0]        mant_in;
  logic               sgn;

  logic               v2_r, v3_r, ov_r;
  logic [33:0]        p2_r, p3_r;
  logic [7:0]         exp2_r, exp3_r;
  logic               sign2_r, sign3_r;
  logic               spec2_r, spec3_r;
  logic [31:0]        specv2_r, specv3_r, spec_nxt;
  logic [pcdq_pkg::CH_W-1:0] ch2_r, ch3_r, och_r;
  logic               last2_r, last3_r, olast_r;
  logic [5:0]         lead;
  logic [5:0]         lead3_r;
  logic signed [10:0] be;
  logic signed [10:0] be3_r;
  logic               zero3_r;
  logic [31:0]        oval_r, res;
  logic [5:0]         nshift;
  logic [33:0]        q, sub;
  logic [7:0]         sh8;
  logic               rnd;
  logic [30:0]        sum;

  logic s2_ready, s3_ready, out_rdy;

  assign out_rdy  = !ov_r || out_ch.ready;
  assign s3_ready = !v3_r || out_rdy;
  assign s2_ready = !v2_r || s3_ready;
  assign op_ready = s2_ready;

  always_comb begin
    diff    = $signed({op.w[9], op.w}) - $signed({{2{op.zp[8]}}, op.zp});
    dneg    = diff[10];
    mag     = dneg ? 10'(-diff) : diff[9:0];
    e_raw   = op.scale[30:23];
    mant_in = {e_raw != 8'd0, op.scale[22:0]};
    sgn     = op.scale[31] ^ dneg;
    if (op.scale[22:0] != 23'd0) begin
      spec_nxt = op.scale | 32'h0040_0000;
    end else if (diff == 11'sd0) begin
      spec_nxt = pcdq_pkg::FP_QNAN;
    end else begin
      spec_nxt = {sgn, 8'hFF, 23'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (s2_ready) begin
      v2_r <= op_valid;
    end
    if (s2_ready && op_valid) begin
      p2_r     <= 34'(mant_in) * 34'(mag);
      exp2_r   <= (e_raw == 8'd0) ? 8'd1 : e_raw;
      sign2_r  <= sgn;
      spec2_r  <= (e_raw == 8'hFF);
      specv2_r <= spec_nxt;
      ch2_r    <= op.ch;
      last2_r  <= op.last;
    end
  end

  // Leading-one stage.
  always_comb begin
    lead = 6'd0;
    for (int i = 0; i < 34; i++) begin
      if (p2_r[i]) lead = 6'(i);
    end
    be = $signed({5'd0, lead}) + $signed({3'd0, exp2_r}) - 11'sd23;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (s3_ready) begin
      v3_r <= v2_r;
    end
    if (s3_ready && v2_r) begin
      p3_r     <= p2_r;
      exp3_r   <= exp2_r;
      lead3_r  <= lead;
      be3_r    <= be;
      zero3_r  <= (p2_r == 34'd0);
      sign3_r  <= sign2_r;
      spec3_r  <= spec2_r;
      specv3_r <= specv2_r;
      ch3_r    <= ch2_r;
      last3_r  <= last2_r;
    end
  end

  // Normalise and round. A subnormal result is exact, so it needs no rounding.
  always_comb begin
    nshift = 6'd33 - lead3_r;
    q      = p3_r << nshift;
    rnd    = q[9] & ((|q[8:0]) | q[10]);
    sum    = {be3_r[7:0], q[32:10]} + 31'(rnd);
    sh8    = exp3_r - 8'd1;
    sub    = p3_r << sh8[4:0];
    if (spec3_r) begin
      res = specv3_r;
    end else if (zero3_r) begin
      res = {sign3_r, 31'd0};
    end else if (be3_r >= 11'sd255) begin
      res = {sign3_r, 8'hFF, 23'd0};
    end else if (be3_r <= 11'sd0) begin
      res = {sign3_r, 8'd0, sub[22:0]};
    end else begin
      res = {sign3_r, sum};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (out_rdy) begin
      ov_r <= v3_r;
    end
    if (out_rdy && v3_r) begin
      oval_r  <= res;
      och_r   <= ch3_r;
      olast_r <= last3_r;
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.value_bits    = oval_r;
  assign out_ch.channel_index = och_r;
  assign out_ch.row_end       = olast_r;

endmodule

// ===== sv/per_channel_dequantizer_top.sv =====
// Top level of the per-channel dequantizer: channel tables, position counter and fp pipeline.
// The block takes one transaction per clock cycle when the result side keeps up; loads and
// restarts give no result, and each weight's result passes through the table read register and
// the three stages of the fp32 multiply, normalise and round pipeline before it reaches the
// result port. The scale and zero-point tables are single-port memories of 1024 entries with
// no clearing after reset; a channel must be loaded before a weight uses it. Writing
// channel_count restarts the channel position at zero.
module per_channel_dequantizer_top (
  input  logic clk,
  input  logic rst_n,
  pcdq_in_if.sink    in_ch,
  pcdq_out_if.source out_ch,
  input  logic                            cfg_we,
  input  logic [pcdq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcdq_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [pcdq_pkg::ETYPE_W-1:0] etype_r;
  logic [pcdq_pkg::COUNT_W-1:0] count_r, cnt_eff;
  logic [pcdq_pkg::CH_W-1:0]    pos_r, ch_cur;
  logic                         last_cur;
  logic signed [9:0]            w_dec;
  logic                         in_acc, weight_acc, load_acc;

  logic [31:0]       scale_mem [pcdq_pkg::MAX_CHANNELS];
  logic [8:0]        zp_mem    [pcdq_pkg::MAX_CHANNELS];

  logic              v1_r, s1_ready, mul_ready;
  pcdq_pkg::op_t     op1_r;

  assign s1_ready    = !v1_r || mul_ready;
  assign in_ch.ready = s1_ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign weight_acc  = in_acc && (in_ch.command == pcdq_pkg::CMD_WEIGHT);
  assign load_acc    = in_acc && (in_ch.command == pcdq_pkg::CMD_LOAD);

  always_comb begin
    if (count_r == '0) begin
      cnt_eff = pcdq_pkg::COUNT_W'(1);
    end else if (count_r > pcdq_pkg::COUNT_W'(pcdq_pkg::MAX_CHANNELS)) begin
      cnt_eff = pcdq_pkg::COUNT_W'(pcdq_pkg::MAX_CHANNELS);
    end else begin
      cnt_eff = count_r;
    end
    ch_cur   = ({1'b0, pos_r} >= cnt_eff) ? '0 : pos_r;
    last_cur = ({1'b0, ch_cur} == cnt_eff - pcdq_pkg::COUNT_W'(1));
    case (etype_r)
      pcdq_pkg::ET_INT8: w_dec = {{2{in_ch.weight_byte[7]}}, in_ch.weight_byte};
      pcdq_pkg::ET_INT4: w_dec = {{6{in_ch.weight_byte[3]}}, in_ch.weight_byte[3:0]};
      pcdq_pkg::ET_INT2: w_dec = {{8{in_ch.weight_byte[1]}}, in_ch.weight_byte[1:0]};
      default:           w_dec = {2'b00, in_ch.weight_byte};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      etype_r <= '0;
      count_r <= pcdq_pkg::COUNT_W'(1);
      pos_r   <= '0;
    end else begin
      if (cfg_we && cfg_index == pcdq_pkg::CFG_ELEMENT_TYPE) begin
        etype_r <= cfg_wdata[pcdq_pkg::ETYPE_W-1:0];
      end
      if (cfg_we && cfg_index == pcdq_pkg::CFG_CHANNEL_COUNT) begin
        count_r <= cfg_wdata[pcdq_pkg::COUNT_W-1:0];
        pos_r   <= '0;
      end else if (in_acc && in_ch.command == pcdq_pkg::CMD_RESTART) begin
        pos_r <= '0;
      end else if (weight_acc) begin
        pos_r <= last_cur ? '0 : ch_cur + pcdq_pkg::CH_W'(1);
      end
    end
  end

  // Table writes and registered reads; one transaction per edge, so no collision.
  always_ff @(posedge clk) begin
    if (load_acc) begin
      scale_mem[in_ch.load_channel] <= in_ch.scale_bits;
      zp_mem[in_ch.load_channel]    <= in_ch.zero_point;
    end
    if (weight_acc) begin
      op1_r.scale <= scale_mem[ch_cur];
      op1_r.zp    <= zp_mem[ch_cur];
      op1_r.w     <= w_dec;
      op1_r.ch    <= ch_cur;
      op1_r.last  <= last_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (s1_ready) begin
      v1_r <= weight_acc;
    end
  end

  pcdq_fmul u_fmul (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (v1_r),
    .op_ready (mul_ready),
    .op       (op1_r),
    .out_ch   (out_ch)
  );

endmodule

// ===== sv/pcdq_checker.sv =====
// Port checker for the per-channel dequantizer and its bind.
module pcdq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] value_bits,
  input logic [9:0]  channel_index,
  input logic        row_end
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(value_bits))
    else $error("result dropped or changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_top_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && channel_index == 10'h3FF |-> row_end)
    else $error("highest channel not flagged as row end");

  a_quiet_nan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && value_bits[30:23] == 8'hFF && value_bits[22:0] != 23'd0 |-> value_bits[22])
    else $error("signalling NaN at output");

endmodule

bind per_channel_dequantizer_top pcdq_checker u_pcdq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .value_bits    (out_ch.value_bits),
  .channel_index (out_ch.channel_index),
  .row_end       (out_ch.row_end)
);

// ===== tb/per_channel_dequantizer_top_tb.sv =====
// Self-checking testbench for the per-channel dequantizer top level.
module per_channel_dequantizer_top_tb;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_LEN     = 400;
  localparam int CALM_FROM    = 900;
  localparam int CALM_TO      = 1400;
  localparam int SETTLE       = 10;

  localparam logic [2:0] ET_SPARE = 3'd7;

  typedef struct {
    logic [1:0]        command;
    logic [9:0]        load_channel;
    logic [31:0]       scale_bits;
    logic signed [8:0] zero_point;
    logic [7:0]        weight_byte;
  } weight_txn_t;

  typedef struct {
    logic [31:0] value_bits;
    logic [9:0]  channel_index;
    logic        row_end;
  } dequant_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [pcdq_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pcdq_pkg::CFG_DATA_W-1:0] cfg_wdata;

  pcdq_in_if  in_if ();
  pcdq_out_if out_if ();

  per_channel_dequantizer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  weight_txn_t pending_items[$];
  dequant_t    expected_values[$];

  // Shadow of the block's state, advanced as transactions are queued.
  logic [2:0]        shadow_etype;
  logic [10:0]       chan_count;
  int                chan_pos;
  logic [31:0]       scale_tab[pcdq_pkg::MAX_CHANNELS];
  logic signed [8:0] zp_tab[pcdq_pkg::MAX_CHANNELS];
  bit                loaded[pcdq_pkg::MAX_CHANNELS];

  int cycle_count;
  int mismatches;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int eff_count();
    if (chan_count == 0) return 1;
    if (chan_count > pcdq_pkg::MAX_CHANNELS) return pcdq_pkg::MAX_CHANNELS;
    return chan_count;
  endfunction

  function automatic int decode_weight(input logic [7:0] b, input logic [2:0] et);
    case (et)
      pcdq_pkg::ET_INT8: return int'($signed(b));
      pcdq_pkg::ET_INT4: return int'($signed(b[3:0]));
      pcdq_pkg::ET_INT2: return int'($signed(b[1:0]));
      default: return int'(b);
    endcase
  endfunction

  // fp32 product of a scale and a small integer, rounded to nearest even.
  function automatic logic [31:0] dequant_value(input logic [31:0] s, input int diff);
    logic   sg;
    int     ex;
    longint m;
    longint p;
    longint q;
    longint rem;
    longint half;
    int     msb;
    int     e_res;
    int     sh;
    sg = s[31] ^ (diff < 0);
    if (s[30:23] == 8'hFF) begin
      if (s[22:0] != 0) return s | 32'h0040_0000;
      if (diff == 0) return pcdq_pkg::FP_QNAN;
      return {sg, 8'hFF, 23'd0};
    end
    m  = (s[30:23] == 0) ? longint'(s[22:0]) : longint'({1'b1, s[22:0]});
    ex = (s[30:23] == 0) ? 1 : int'(s[30:23]);
    p  = m * longint'((diff < 0) ? -diff : diff);
    if (p == 0) return {sg, 31'd0};
    msb = 0;
    for (int i = 0; i < 40; i++) if (p[i]) msb = i;
    e_res = msb + ex - 23;
    sh = (e_res >= 1) ? msb - 23 : 1 - ex;
    if (sh <= 0) begin
      q = p << (-sh);
    end else begin
      q    = p >> sh;
      rem  = p & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q++;
    end
    if (e_res >= 1) q = q + (longint'(e_res - 1) << 23);
    if (q >= 64'h7F80_0000) return {sg, 8'hFF, 23'd0};
    return {sg, q[30:0]};
  endfunction

  function automatic logic [31:0] rand_scale();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return {r[31], 8'hFF, r[22:1], 1'b1};
      1: return {r[31], 8'hFF, 23'd0};
      2: return {r[31], 31'd0};
      3: return {r[31], 8'h00, r[22:0]};
      4: return {r[31], 4'hF, r[3:0] == 4'hF ? 4'hE : r[3:0], r[22:0]};
      5: return {r[31], 3'b000, r[26:23] | 4'h1, r[22:0]};
      default: return r;
    endcase
  endfunction

  task automatic send(input logic [1:0] cmd, input logic [9:0] ch, input logic [31:0] sc,
                      input logic signed [8:0] zp, input logic [7:0] wb);
    weight_txn_t t;
    dequant_t    r;
    int          c;
    int          eff;
    t.command = cmd; t.load_channel = ch; t.scale_bits = sc;
    t.zero_point = zp; t.weight_byte = wb;
    pending_items.push_back(t);
    eff = eff_count();
    case (cmd)
      pcdq_pkg::CMD_LOAD: begin
        scale_tab[ch] = sc;
        zp_tab[ch]    = zp;
        loaded[ch]    = 1'b1;
      end
      pcdq_pkg::CMD_RESTART: chan_pos = 0;
      pcdq_pkg::CMD_WEIGHT: begin
        c = (chan_pos >= eff) ? 0 : chan_pos;
        r.value_bits    = dequant_value(scale_tab[c],
                                        decode_weight(wb, shadow_etype) - int'(zp_tab[c]));
        r.channel_index = c[9:0];
        r.row_end       = (c == eff - 1);
        chan_pos        = r.row_end ? 0 : c + 1;
        expected_values.push_back(r);
      end
      default: ;
    endcase
  endtask

  // A weight for a channel never loaded is preceded by a load of that channel.
  task automatic send_weight(input logic [7:0] wb);
    int c;
    c = (chan_pos >= eff_count()) ? 0 : chan_pos;
    if (!loaded[c]) send(pcdq_pkg::CMD_LOAD, c[9:0], rand_scale(), 9'($urandom),
                         8'($urandom));
    send(pcdq_pkg::CMD_WEIGHT, 10'($urandom), $urandom, 9'($urandom), wb);
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_if.valid || expected_values.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [pcdq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pcdq_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == pcdq_pkg::CFG_ELEMENT_TYPE) begin
      shadow_etype = val[2:0];
    end else begin
      chan_count = val;
      chan_pos   = 0;
    end
  endtask

  // Input driver: a transaction stays on offer until it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) void'(pending_items.pop_front());
      if (in_if.valid && !in_if.ready) begin
        in_if.valid <= 1'b1;
      end else if (pending_items.size() != 0 &&
                   ((cycle_count >= CALM_FROM && cycle_count < CALM_TO) ||
                    $urandom_range(0, 99) >= 18)) begin
        in_if.valid        <= 1'b1;
        in_if.command      <= pending_items[0].command;
        in_if.load_channel <= pending_items[0].load_channel;
        in_if.scale_bits   <= pending_items[0].scale_bits;
        in_if.zero_point   <= pending_items[0].zero_point;
        in_if.weight_byte  <= pending_items[0].weight_byte;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Length of the long hold-off on the result side, counted down cycle by cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (cycle_count == HOLD_AT) begin
      hold_left <= HOLD_LEN;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result side back-pressure, with one long hold-off to fill the pipeline.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (cycle_count == HOLD_AT || hold_left > 0) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= (cycle_count >= CALM_FROM && cycle_count < CALM_TO) ||
                      $urandom_range(0, 99) >= 18;
    end
  end

  always @(posedge clk) begin
    dequant_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_values.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: value %h channel %0d row_end %b",
                   out_if.value_bits, out_if.channel_index, out_if.row_end);
      end else begin
        e = expected_values.pop_front();
        if (out_if.value_bits !== e.value_bits || out_if.channel_index !== e.channel_index ||
            out_if.row_end !== e.row_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %h/%0d/%b actual %h/%0d/%b",
                     e.value_bits, e.channel_index, e.row_end,
                     out_if.value_bits, out_if.channel_index, out_if.row_end);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int eff;
    int r;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    shadow_etype = '0; chan_count = 11'd1; chan_pos = 0;
    for (int i = 0; i < pcdq_pkg::MAX_CHANNELS; i++) loaded[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: special scales, extreme weights and zero points.
    write_cfg(pcdq_pkg::CFG_ELEMENT_TYPE, 11'(pcdq_pkg::ET_INT8));
    write_cfg(pcdq_pkg::CFG_CHANNEL_COUNT, 11'd4);
    send(pcdq_pkg::CMD_LOAD, 10'd0, 32'h3F80_0000, 9'sd0, 8'h00);
    send(pcdq_pkg::CMD_LOAD, 10'd1, 32'h7F80_0001, -9'sd256, 8'hFF);
    send(pcdq_pkg::CMD_LOAD, 10'd2, 32'hFF80_0000, 9'sd255, 8'h00);
    send(pcdq_pkg::CMD_LOAD, 10'd3, 32'h0000_0001, -9'sd1, 8'hFF);
    send_weight(8'h7F);
    send_weight(8'h80);
    send_weight(8'hFF);
    send_weight(8'h00);
    send(pcdq_pkg::CMD_LOAD, 10'd0, 32'h7F7F_FFFF, -9'sd256, 8'h00);
    send(pcdq_pkg::CMD_LOAD, 10'd1023, 32'h8000_0000, 9'sd7, 8'h55);
    send_weight(8'hFF);
    send(pcdq_pkg::CMD_RESTART, 10'h3FF, 32'hFFFF_FFFF, -9'sd1, 8'hFF);
    send_weight(8'h01);
    send(pcdq_pkg::CMD_NOP, 10'h2AA, 32'h5555_5555, 9'sd170, 8'hAA);
    send_weight(8'hFE);
    send_weight(8'h00);
    send_weight(8'h80);
    wait_idle();

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0: begin
          write_cfg(pcdq_pkg::CFG_ELEMENT_TYPE, 11'(pcdq_pkg::ET_UINT2));
          write_cfg(pcdq_pkg::CFG_CHANNEL_COUNT, 11'd1);
        end
        1: begin
          write_cfg(pcdq_pkg::CFG_ELEMENT_TYPE, 11'(ET_SPARE));
          write_cfg(pcdq_pkg::CFG_CHANNEL_COUNT, 11'd1024);
        end
        2: begin
          write_cfg(pcdq_pkg::CFG_ELEMENT_TYPE, 11'(pcdq_pkg::ET_INT8));
          write_cfg(pcdq_pkg::CFG_CHANNEL_COUNT, 11'd0);
        end
        3: begin
          write_cfg(pcdq_pkg::CFG_ELEMENT_TYPE, 11'(pcdq_pkg::ET_INT4));
          write_cfg(pcdq_pkg::CFG_CHANNEL_COUNT, 11'd2047);
        end
        default: begin
          write_cfg(pcdq_pkg::CFG_ELEMENT_TYPE, 11'($urandom_range(0, 7)));
          write_cfg(pcdq_pkg::CFG_CHANNEL_COUNT, 11'($urandom_range(1, 16)));
        end
      endcase
      for (int n = 0; n < 100; n++) begin
        eff = eff_count();
        r = $urandom_range(0, 99);
        if (r < 68) begin
          send_weight(8'($urandom));
        end else if (r < 88) begin
          send(pcdq_pkg::CMD_LOAD,
               (r < 80) ? 10'($urandom_range(0, eff - 1)) : 10'($urandom),
               rand_scale(), 9'($urandom), 8'($urandom));
        end else if (r < 94) begin
          send(pcdq_pkg::CMD_RESTART, 10'($urandom), $urandom, 9'($urandom), 8'($urandom));
        end else begin
          send(pcdq_pkg::CMD_NOP, 10'($urandom), $urandom, 9'($urandom), 8'($urandom));
        end
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/pcdq_pkg.sv
sv/pcdq_in_if.sv
sv/pcdq_out_if.sv
sv/pcdq_fmul.sv
sv/per_channel_dequantizer_top.sv
sv/pcdq_checker.sv
tb/per_channel_dequantizer_top_tb.sv
